[hw/rtl/cvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_pkg
// Types, sizes and codes shared by the cosine top-k vector search block.
// ----------------------------------------------------------------------------
package cvs_pkg;

  localparam int MAX_ENTRIES  = 64;
  localparam int MAX_DIM      = 64;
  localparam int ELEMENT_BITS = 16;

  localparam int ENT_W   = $clog2(MAX_ENTRIES);
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int LEN_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = ENT_W + DIM_W;
  localparam int ID_W    = 32;
  localparam int SCORE_W = 16;
  localparam int PROD_W  = 2 * ELEMENT_BITS;
  localparam int ACC_W   = PROD_W + DIM_W + 1;

  // Root unit: norms are normalized into a 62-bit value, root is 31 bits.
  localparam int ROOT_W    = 31;
  localparam int RX_W      = 2 * ROOT_W + 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SH_W      = 6;
  localparam int SHIFT_MAX = RX_W - 4;
  localparam int DEN_W     = 2 * ROOT_W;
  localparam int FRAC_BITS = SCORE_W - 1;
  localparam int DCNT_W    = $clog2(ACC_W + FRAC_BITS + SHIFT_MAX + 1);

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MATCH   = 2'd0,
    ST_DONE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                     command;
    logic [ID_W-1:0]                entry_id;
    logic signed [ELEMENT_BITS-1:0] element;
    logic                           last_element;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]           result_id;
    logic signed [SCORE_W-1:0] score;
    logic [1:0]                status;
    logic [CNT_W-1:0]          entry_count;
    logic                      last_result;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ENT_START,
    OP_LEN_RD,
    OP_ENT_NEXT,
    OP_MAC_START,
    OP_MAC_RUN,
    OP_NORM_A,
    OP_NORM_B,
    OP_DEN,
    OP_DIV_START,
    OP_SCORE_WR,
    OP_SCORE_ZERO,
    OP_RANK_START,
    OP_SCAN_START,
    OP_SCAN,
    OP_ID_RD,
    OP_RANK_NEXT
  } dp_op_e;

  typedef enum logic [1:0] {
    EM_CLEAR,
    EM_ADD,
    EM_NOMATCH,
    EM_HIT
  } emit_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
    logic   emit;
    emit_e  kind;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic e_end;
    logic len_match;
    logic mac_done;
    logic zero_norm;
    logic rt_idle;
    logic dv_idle;
    logic scan_done;
    logic nmatch_zero;
    logic rank_end;
    logic last_rank;
  } dp_stat_t;

endpackage

[hw/rtl/cvs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/cvs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_ctrl
// Sequencer for load, scoring and ranking; drives datapath commands.
// ----------------------------------------------------------------------------
module cvs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  input  logic              in_last,
  output logic              in_ready,
  input  cvs_pkg::dp_stat_t stat,
  output cvs_pkg::dp_cmd_t  cmd
);
  import cvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENT,
    S_LEN,
    S_MAC,
    S_NA,
    S_NB,
    S_DEN,
    S_DIV,
    S_RANK,
    S_SCAN,
    S_ID,
    S_NOMATCH
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '{accept: accept, op: OP_NONE, emit: 1'b0, kind: EM_CLEAR, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_CLEAR) begin
            cmd.emit = 1'b1;
            cmd.kind = EM_CLEAR;
          end else if (in_command == CMD_ADD && in_last) begin
            cmd.emit = 1'b1;
            cmd.kind = EM_ADD;
          end else if (in_command == CMD_QUERY && in_last) begin
            cmd.op     = OP_ENT_START;
            state_next = S_ENT;
          end
        end
      end
      S_ENT: begin
        if (stat.e_end) begin
          cmd.op     = OP_RANK_START;
          state_next = S_RANK;
        end else begin
          cmd.op     = OP_LEN_RD;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (stat.len_match) begin
          cmd.op     = OP_MAC_START;
          state_next = S_MAC;
        end else begin
          cmd.op     = OP_ENT_NEXT;
          state_next = S_ENT;
        end
      end
      S_MAC: begin
        if (!stat.mac_done) begin
          cmd.op = OP_MAC_RUN;
        end else if (stat.zero_norm) begin
          cmd.op     = OP_SCORE_ZERO;
          state_next = S_ENT;
        end else begin
          cmd.op     = OP_NORM_A;
          state_next = S_NA;
        end
      end
      S_NA: begin
        if (stat.rt_idle) begin
          cmd.op     = OP_NORM_B;
          state_next = S_NB;
        end
      end
      S_NB: begin
        if (stat.rt_idle) begin
          cmd.op     = OP_DEN;
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        cmd.op     = OP_DIV_START;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.dv_idle) begin
          cmd.op     = OP_SCORE_WR;
          state_next = S_ENT;
        end
      end
      S_RANK: begin
        if (stat.nmatch_zero) begin
          state_next = S_NOMATCH;
        end else if (stat.rank_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_SCAN_START;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.op     = OP_ID_RD;
          state_next = S_ID;
        end else begin
          cmd.op = OP_SCAN;
        end
      end
      S_ID: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EM_HIT;
          cmd.last   = stat.last_rank;
          cmd.op     = OP_RANK_NEXT;
          state_next = S_RANK;
        end
      end
      S_NOMATCH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EM_NOMATCH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/cvs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_dp
// Datapath: vector store, dot/norm accumulation, root and divide units,
// score ranking and the output register.
// ----------------------------------------------------------------------------
module cvs_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cvs_pkg::CNT_W-1:0]   cfg_wdata,
  input  cvs_pkg::in_item_t           in_data,
  input  cvs_pkg::dp_cmd_t            cmd,
  output cvs_pkg::dp_stat_t           stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cvs_pkg::out_item_t          out_data
);
  import cvs_pkg::*;

  // Control and counters.
  logic [CNT_W-1:0] count, count_next, top_k, e, j, rank, nmatch, limit;
  logic [LEN_W-1:0] ec, qlen, i, len_fin;
  logic [MAX_ENTRIES-1:0] match, taken;

  // Memory ports.
  logic signed [ELEMENT_BITS-1:0] vec_rdata, q_rdata;
  logic [LEN_W-1:0]               len_rdata;
  logic [ID_W-1:0]                id_rdata;
  logic signed [SCORE_W-1:0]      score_rdata, score_wdata;

  // Accumulation pipeline.
  logic                     mv1, mv2;
  logic signed [PROD_W-1:0] pd, pa, pb;
  logic signed [ACC_W-1:0]  dot;
  logic [ACC_W-1:0]         na, nb, mag;

  // Root unit.
  logic               rt_busy, rt_shift, rt_sel, rt_ge;
  logic [RX_W-1:0]    rt_x;
  logic [SH_W-1:0]    rt_s, sa, sb;
  logic [REM_W-1:0]   rt_rem;
  logic [REM_W+1:0]   rt_rem_t, rt_trial;
  logic [ROOT_W-1:0]  rt_root, rt_root_fin, ra, rb;
  logic [$clog2(ROOT_W)-1:0] rt_cnt;

  // Divide unit.
  logic               dv_busy, dv_neg, dv_ovf, dv_ge, dv_big;
  logic [DEN_W-1:0]   den, dv_r;
  logic [DEN_W:0]     dv_r_t;
  logic [ACC_W-1:0]   dv_num;
  logic [SCORE_W-1:0] dv_q;
  logic [DCNT_W-1:0]  dv_cnt;
  logic signed [SCORE_W-1:0] div_score;

  // Ranking.
  logic                      sv1, best_v, cand;
  logic [ENT_W-1:0]          sj, best_idx;
  logic signed [SCORE_W-1:0] best_s;

  logic is_clear, is_add, is_query, ec_room, full, add_fin, mac_issue, scan_issue;

  assign is_clear = cmd.accept && in_data.command == CMD_CLEAR;
  assign is_add   = cmd.accept && in_data.command == CMD_ADD;
  assign is_query = cmd.accept && in_data.command == CMD_QUERY;
  assign ec_room  = ec < LEN_W'(MAX_DIM);
  assign full     = count >= CNT_W'(MAX_ENTRIES);
  assign add_fin  = is_add && in_data.last_element;
  assign len_fin  = ec + LEN_W'(ec_room);
  assign mac_issue  = cmd.op == OP_MAC_RUN && i != qlen;
  assign scan_issue = cmd.op == OP_SCAN && j != count;

  always_comb begin
    count_next = count;
    if (is_clear) begin
      count_next = '0;
    end else if (add_fin && !full) begin
      count_next = count + CNT_W'(1);
    end
  end

  cvs_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_ENTRIES * MAX_DIM)) u_vec_ram (
    .clk   (clk),
    .we    (is_add && ec_room && !full),
    .waddr ({count[ENT_W-1:0], ec[DIM_W-1:0]}),
    .wdata (in_data.element),
    .re    (mac_issue),
    .raddr ({e[ENT_W-1:0], i[DIM_W-1:0]}),
    .rdata (vec_rdata)
  );

  cvs_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_DIM)) u_query_ram (
    .clk   (clk),
    .we    (is_query && ec_room),
    .waddr (ec[DIM_W-1:0]),
    .wdata (in_data.element),
    .re    (mac_issue),
    .raddr (i[DIM_W-1:0]),
    .rdata (q_rdata)
  );

  cvs_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk   (clk),
    .we    (add_fin && !full),
    .waddr (count[ENT_W-1:0]),
    .wdata (len_fin),
    .re    (cmd.op == OP_LEN_RD),
    .raddr (e[ENT_W-1:0]),
    .rdata (len_rdata)
  );

  cvs_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_id_ram (
    .clk   (clk),
    .we    (add_fin && !full),
    .waddr (count[ENT_W-1:0]),
    .wdata (in_data.entry_id),
    .re    (cmd.op == OP_ID_RD),
    .raddr (best_idx),
    .rdata (id_rdata)
  );

  assign score_wdata = (cmd.op == OP_SCORE_ZERO) ? '0 : div_score;

  cvs_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_ENTRIES)) u_score_ram (
    .clk   (clk),
    .we    (cmd.op == OP_SCORE_WR || cmd.op == OP_SCORE_ZERO),
    .waddr (e[ENT_W-1:0]),
    .wdata (score_wdata),
    .re    (scan_issue),
    .raddr (j[ENT_W-1:0]),
    .rdata (score_rdata)
  );

  // One digit pair of the square root per cycle.
  assign rt_rem_t    = {rt_rem, rt_x[RX_W-3:RX_W-4]};
  assign rt_trial    = (REM_W + 2)'({rt_root, 2'b01});
  assign rt_ge       = rt_rem_t >= rt_trial;
  assign rt_root_fin = {rt_root[ROOT_W-2:0], rt_ge};

  // One quotient bit per cycle; numerator bits run out into zeros.
  assign mag    = dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);
  assign dv_r_t = {dv_r, dv_num[ACC_W-1]};
  assign dv_ge  = dv_r_t >= {1'b0, den};
  assign dv_big = dv_ovf | dv_q[SCORE_W-1];

  always_comb begin
    if (dv_neg) begin
      div_score = dv_big ? SCORE_MIN : -$signed(dv_q);
    end else begin
      div_score = dv_big ? SCORE_MAX : $signed(dv_q);
    end
  end

  assign cand = sv1 && match[sj] && !taken[sj];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ec        <= '0;
      top_k     <= '0;
      out_valid <= 1'b0;
      rt_busy   <= 1'b0;
      dv_busy   <= 1'b0;
      mv1       <= 1'b0;
      mv2       <= 1'b0;
      sv1       <= 1'b0;
    end else begin
      if (cfg_we) begin
        top_k <= cfg_wdata;
      end
      count <= count_next;
      if (is_clear) begin
        ec <= '0;
      end else if (is_add || is_query) begin
        if (in_data.last_element) begin
          ec <= '0;
        end else if (ec_room) begin
          ec <= ec + LEN_W'(1);
        end
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      mv1 <= mac_issue;
      mv2 <= mv1;
      sv1 <= scan_issue;

      if (cmd.op == OP_NORM_A || cmd.op == OP_NORM_B) begin
        rt_busy <= 1'b1;
      end else if (rt_busy && !rt_shift && rt_cnt == ($clog2(ROOT_W))'(ROOT_W - 1)) begin
        rt_busy <= 1'b0;
      end

      if (cmd.op == OP_DIV_START) begin
        dv_busy <= 1'b1;
      end else if (dv_busy && dv_cnt == DCNT_W'(1)) begin
        dv_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_query && in_data.last_element) begin
      qlen <= len_fin;
    end

    if (cmd.emit) begin
      out_data.entry_count <= count_next;
      out_data.last_result <= cmd.last;
      case (cmd.kind)
        EM_CLEAR: begin
          out_data.result_id <= '0;
          out_data.score     <= '0;
          out_data.status    <= ST_DONE;
        end
        EM_ADD: begin
          out_data.result_id <= in_data.entry_id;
          out_data.score     <= '0;
          out_data.status    <= full ? ST_FULL : ST_DONE;
        end
        EM_NOMATCH: begin
          out_data.result_id <= '0;
          out_data.score     <= '0;
          out_data.status    <= ST_NOMATCH;
        end
        default: begin
          out_data.result_id <= id_rdata;
          out_data.score     <= best_s;
          out_data.status    <= ST_MATCH;
        end
      endcase
    end

    // Entry walk.
    case (cmd.op)
      OP_ENT_START: begin
        e      <= '0;
        nmatch <= '0;
        match  <= '0;
      end
      OP_ENT_NEXT: e <= e + CNT_W'(1);
      OP_SCORE_WR, OP_SCORE_ZERO: begin
        match[e[ENT_W-1:0]] <= 1'b1;
        nmatch              <= nmatch + CNT_W'(1);
        e                   <= e + CNT_W'(1);
      end
      OP_RANK_START: begin
        rank  <= '0;
        taken <= '0;
        limit <= (top_k != '0 && top_k < nmatch) ? top_k : nmatch;
      end
      OP_RANK_NEXT: rank <= rank + CNT_W'(1);
      OP_ID_RD: taken[best_idx] <= 1'b1;
      default: ;
    endcase

    // Dot product and norms.
    if (cmd.op == OP_MAC_START) begin
      i   <= '0;
      dot <= '0;
      na  <= '0;
      nb  <= '0;
    end else begin
      if (mac_issue) begin
        i <= i + LEN_W'(1);
      end
      if (mv2) begin
        dot <= dot + ACC_W'(pd);
        na  <= na + ACC_W'(pa);
        nb  <= nb + ACC_W'(pb);
      end
    end
    if (mv1) begin
      pd <= q_rdata * vec_rdata;
      pa <= q_rdata * q_rdata;
      pb <= vec_rdata * vec_rdata;
    end

    // Norm alignment by even shifts, then the root.
    if (cmd.op == OP_NORM_A || cmd.op == OP_NORM_B) begin
      rt_x     <= (cmd.op == OP_NORM_A) ? RX_W'(na) : RX_W'(nb);
      rt_sel   <= cmd.op == OP_NORM_B;
      rt_s     <= '0;
      rt_shift <= 1'b1;
      rt_rem   <= '0;
      rt_root  <= '0;
      rt_cnt   <= '0;
    end else if (rt_busy) begin
      if (rt_shift) begin
        if (rt_s < SH_W'(SHIFT_MAX) && rt_x[RX_W-1:RX_W-4] == '0) begin
          rt_x <= rt_x << 2;
          rt_s <= rt_s + SH_W'(2);
        end else begin
          rt_shift <= 1'b0;
        end
      end else begin
        rt_rem  <= rt_ge ? REM_W'(rt_rem_t - rt_trial) : REM_W'(rt_rem_t);
        rt_root <= rt_root_fin;
        rt_x    <= rt_x << 2;
        rt_cnt  <= rt_cnt + 1'b1;
        if (rt_cnt == ($clog2(ROOT_W))'(ROOT_W - 1)) begin
          if (rt_sel) begin
            rb <= rt_root_fin;
            sb <= rt_s;
          end else begin
            ra <= rt_root_fin;
            sa <= rt_s;
          end
        end
      end
    end

    if (cmd.op == OP_DEN) begin
      den <= ra * rb;
    end

    // Long division of |dot| << (15 + sa/2 + sb/2) by the root product.
    if (cmd.op == OP_DIV_START) begin
      dv_num <= mag;
      dv_neg <= dot[ACC_W-1];
      dv_r   <= '0;
      dv_q   <= '0;
      dv_ovf <= 1'b0;
      dv_cnt <= DCNT_W'(ACC_W + FRAC_BITS) + DCNT_W'(sa >> 1) + DCNT_W'(sb >> 1);
    end else if (dv_busy) begin
      dv_num <= dv_num << 1;
      dv_r   <= dv_ge ? DEN_W'(dv_r_t - {1'b0, den}) : DEN_W'(dv_r_t);
      dv_q   <= {dv_q[SCORE_W-2:0], dv_ge};
      dv_ovf <= dv_ovf | dv_q[SCORE_W-1];
      dv_cnt <= dv_cnt - DCNT_W'(1);
    end

    // Best-score scan; strictly greater wins so ties stay with the earlier entry.
    if (cmd.op == OP_SCAN_START) begin
      j      <= '0;
      best_v <= 1'b0;
    end else begin
      if (scan_issue) begin
        j  <= j + CNT_W'(1);
        sj <= j[ENT_W-1:0];
      end
      if (cand && (!best_v || score_rdata > best_s)) begin
        best_v   <= 1'b1;
        best_s   <= score_rdata;
        best_idx <= sj;
      end
    end
  end

  assign stat.out_free    = !out_valid || out_ready;
  assign stat.e_end       = e == count;
  assign stat.len_match   = len_rdata == qlen;
  assign stat.mac_done    = i == qlen && !mv1 && !mv2;
  assign stat.zero_norm   = na == '0 || nb == '0;
  assign stat.rt_idle     = !rt_busy;
  assign stat.dv_idle     = !dv_busy;
  assign stat.scan_done   = j == count && !sv1;
  assign stat.nmatch_zero = nmatch == '0;
  assign stat.rank_end    = rank == limit;
  assign stat.last_rank   = rank + CNT_W'(1) == limit;

endmodule

[hw/rtl/cosine_top_k_vector_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_top_k_vector_search
// Brute-force cosine similarity store with top-k ranked query results.
// ----------------------------------------------------------------------------
// Words arrive on in_valid/in_ready, one vector element per word; results
// leave on out_valid/out_ready. top_k is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle; the block does not check.
// Element words of an add or query are taken while in_ready is high. A clear
// or the last element of an add produces its one result word in the output
// register on the next cycle.
// The last element of a query starts a walk over all stored entries. An
// entry of another length is skipped once its length is read. A matching
// entry goes through the length check and multiply-accumulate, the two
// norm shifts and square roots, the root product, and
// 39 + 15 + sa/2 + sb/2 divider steps (at most 114) before its score is
// stored; a zero norm stores score zero without the root and divide.
// Each ranked result then needs a scan of the score memory for the next best.
// No new word is accepted until the last result of a query is in the
// output register. A stalled receiver holds the output register and the
// sequencer waits; nothing is dropped.
// Reset empties the store and clears top_k; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cosine_top_k_vector_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cvs_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cvs_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cvs_pkg::out_item_t        out_data
);
  import cvs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cvs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_last    (in_data.last_element),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cvs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
